/* hdl/sgc_pkg.sv */
// Package for the segment grid crossings unit: shared types and constants.
// Used by every module in hdl; depends on nothing.
package sgc_pkg;

    localparam int CoordW = 17;
    localparam int TFrac = 24;
    localparam int TW = TFrac + 1;
    localparam logic [CoordW-1:0] CoordOne = 17'h10000;

    localparam logic [2:0] KindStart = 3'd0;
    localparam logic [2:0] KindVert = 3'd1;
    localparam logic [2:0] KindHorz = 3'd2;
    localparam logic [2:0] KindCorner = 3'd3;
    localparam logic [2:0] KindEnd = 3'd4;

    localparam logic RegGridX = 1'b0;
    localparam logic RegGridY = 1'b1;

    localparam logic [1:0] SelStart = 2'd0;
    localparam logic [1:0] SelEnd = 2'd1;
    localparam logic [1:0] SelCross = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT_START,
        ST_XT,
        ST_YT,
        ST_PICK,
        ST_LERP,
        ST_EMIT,
        ST_EMIT_END
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic start_x_div;
        logic start_y_div;
        logic start_lerp;
        logic adv_x;
        logic adv_y;
        logic lerp_y;
        logic [1:0] emit_sel;
        logic [2:0] kind;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic lerp_done;
        logic x_more;
        logic y_more;
        logic x_first;
        logic corner;
    } status_t;

endpackage

/* hdl/sgc_datapath.sv */
// Datapath of the segment grid crossings unit: coordinates, line indexes,
// a shared bit-serial divider and a shift-add interpolator. Uses sgc_pkg.
module sgc_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sgc_pkg::cmd_t               cmd,
    output sgc_pkg::status_t            sts,
    input  logic [5:0]                  pts_x,
    input  logic [5:0]                  pts_y,
    input  logic [4*sgc_pkg::CoordW-1:0] in_data,
    output logic [sgc_pkg::CoordW-1:0]  out_x,
    output logic [sgc_pkg::CoordW-1:0]  out_y
);
    localparam int CW = sgc_pkg::CoordW;
    localparam int TW = sgc_pkg::TW;
    localparam int DW = sgc_pkg::TFrac + CW;
    localparam int AW = TW + CW;

    logic [CW-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [4:0] segx_reg, segy_reg;
    logic [5:0] curx_reg, endx_reg, cury_reg, endy_reg;
    logic dirx_reg, diry_reg, mx_reg, my_reg;
    logic [CW-1:0] vx_reg, vy_reg;
    logic [TW-1:0] tx_reg, ty_reg;
    logic [DW-1:0] rem_reg, quo_reg;
    logic [CW-1:0] den_reg;
    logic [5:0] dcnt_reg;
    logic dbusy_reg, dsel_reg;
    logic [TW-1:0] lt_reg;
    logic [CW-1:0] la_reg, lb_reg;
    logic [AW-1:0] acca_reg, accb_reg;
    logic [4:0] lcnt_reg;
    logic lbusy_reg;
    logic [CW-1:0] lres_reg;

    function automatic logic [4:0] clampn(input logic [5:0] n);
        if (n < 6'd2) return 5'd1;
        if (n > 6'd32) return 5'd31;
        return 5'(n - 6'd1);
    endfunction

    function automatic logic [CW-1:0] sat(input logic [CW-1:0] c);
        return (c > sgc_pkg::CoordOne) ? sgc_pkg::CoordOne : c;
    endfunction

    // The shared divider first gives the grid line position, then the t value.
    logic [CW-1:0] sx, sy, ex, ey;
    logic [4:0] nsx, nsy;
    logic [21:0] px0, px1, py0, py1;
    assign sx = sat(in_data[CW-1:0]);
    assign sy = sat(in_data[2*CW-1:CW]);
    assign ex = sat(in_data[3*CW-1:2*CW]);
    assign ey = sat(in_data[4*CW-1:3*CW]);
    assign nsx = clampn(pts_x);
    assign nsy = clampn(pts_y);

    logic [5:0] ix0, ix1, iy0, iy1;
    assign px0 = x0_reg * segx_reg;
    assign px1 = x1_reg * segx_reg;
    assign py0 = y0_reg * segy_reg;
    assign py1 = y1_reg * segy_reg;
    assign ix0 = px0[21:16];
    assign ix1 = px1[21:16];
    assign iy0 = py0[21:16];
    assign iy1 = py1[21:16];

    logic [5:0] curx_nx, cury_nx;
    assign curx_nx = !cmd.adv_x ? curx_reg
                   : (dirx_reg ? curx_reg + 6'd1 : curx_reg - 6'd1);
    assign cury_nx = !cmd.adv_y ? cury_reg
                   : (diry_reg ? cury_reg + 6'd1 : cury_reg - 6'd1);

    logic [CW-1:0] lenx, leny, dx, dy, c0x, c0y;
    assign lenx = (x0_reg > x1_reg) ? x0_reg - x1_reg : x1_reg - x0_reg;
    assign leny = (y0_reg > y1_reg) ? y0_reg - y1_reg : y1_reg - y0_reg;

    logic [DW-1:0] trial_rem;
    logic [DW:0] trial;
    assign trial_rem = {rem_reg[DW-2:0], quo_reg[DW-1]};
    assign trial = {1'b0, trial_rem} - {{(DW+1-CW){1'b0}}, den_reg};

    logic phase_reg;
    logic [CW-1:0] vsel;
    assign vsel = quo_reg[CW-1:0];
    assign c0x = x0_reg;
    assign c0y = y0_reg;
    assign dx = (vsel > c0x) ? vsel - c0x : c0x - vsel;
    assign dy = (vsel > c0y) ? vsel - c0y : c0y - vsel;

    logic [DW-1:0] tq;
    assign tq = quo_reg;

    logic [AW-1:0] lsum;
    assign lsum = (AW'(la_reg) << sgc_pkg::TFrac) - acca_reg + accb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            lbusy_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                x0_reg <= sx; y0_reg <= sy; x1_reg <= ex; y1_reg <= ey;
                segx_reg <= nsx; segy_reg <= nsy;
            end
            if (cmd.setup) begin
                dirx_reg <= ix0 < ix1;
                diry_reg <= iy0 < iy1;
                curx_reg <= (ix0 < ix1) ? ix0 + 6'd1 : ix0;
                endx_reg <= (ix0 < ix1) ? ix1 : ix1 + 6'd1;
                mx_reg <= (ix0 != ix1) && (lenx != '0);
                cury_reg <= (iy0 < iy1) ? iy0 + 6'd1 : iy0;
                endy_reg <= (iy0 < iy1) ? iy1 : iy1 + 6'd1;
                my_reg <= (iy0 != iy1) && (leny != '0);
            end
            if (cmd.adv_x) begin
                if (curx_reg == endx_reg) mx_reg <= 1'b0;
                curx_reg <= curx_nx;
            end
            if (cmd.adv_y) begin
                if (cury_reg == endy_reg) my_reg <= 1'b0;
                cury_reg <= cury_nx;
            end
            if (cmd.start_x_div || cmd.start_y_div) begin
                dsel_reg <= cmd.start_y_div;
                phase_reg <= 1'b0;
                dbusy_reg <= 1'b1;
                rem_reg <= '0;
                dcnt_reg <= 6'(DW);
                quo_reg <= DW'({(cmd.start_y_div ? cury_nx : curx_nx), 16'h0000});
                den_reg <= CW'(cmd.start_y_div ? segy_reg : segx_reg);
            end else if (dbusy_reg) begin
                if (dcnt_reg != '0) begin
                    rem_reg <= trial[DW] ? trial_rem : trial[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], ~trial[DW]};
                    dcnt_reg <= dcnt_reg - 6'd1;
                end else if (!phase_reg) begin
                    phase_reg <= 1'b1;
                    rem_reg <= '0;
                    dcnt_reg <= 6'(DW);
                    if (dsel_reg) begin
                        vy_reg <= vsel;
                        quo_reg <= {dy, {sgc_pkg::TFrac{1'b0}}};
                        den_reg <= leny;
                    end else begin
                        vx_reg <= vsel;
                        quo_reg <= {dx, {sgc_pkg::TFrac{1'b0}}};
                        den_reg <= lenx;
                    end
                end else begin
                    dbusy_reg <= 1'b0;
                    if (dsel_reg)
                        ty_reg <= (tq > DW'(1 << sgc_pkg::TFrac)) ? TW'(1 << sgc_pkg::TFrac)
                                                                 : tq[TW-1:0];
                    else
                        tx_reg <= (tq > DW'(1 << sgc_pkg::TFrac)) ? TW'(1 << sgc_pkg::TFrac)
                                                                 : tq[TW-1:0];
                end
            end
            if (cmd.start_lerp) begin
                lbusy_reg <= 1'b1;
                lt_reg <= cmd.lerp_y ? tx_reg : ty_reg;
                la_reg <= cmd.lerp_y ? y0_reg : x0_reg;
                lb_reg <= cmd.lerp_y ? y1_reg : x1_reg;
                acca_reg <= '0;
                accb_reg <= '0;
                lcnt_reg <= 5'(TW);
            end else if (lbusy_reg) begin
                if (lcnt_reg != '0) begin
                    acca_reg <= (acca_reg << 1) + (lt_reg[TW-1] ? AW'(la_reg) : '0);
                    accb_reg <= (accb_reg << 1) + (lt_reg[TW-1] ? AW'(lb_reg) : '0);
                    lt_reg <= lt_reg << 1;
                    lcnt_reg <= lcnt_reg - 5'd1;
                end else begin
                    lbusy_reg <= 1'b0;
                    lres_reg <= lsum[sgc_pkg::TFrac +: CW];
                end
            end
        end
    end

    assign sts.div_done = !dbusy_reg;
    assign sts.lerp_done = !lbusy_reg;
    assign sts.x_more = mx_reg;
    assign sts.y_more = my_reg;
    assign sts.x_first = tx_reg < ty_reg;
    assign sts.corner = tx_reg == ty_reg;

    always_comb begin
        case (cmd.emit_sel)
            sgc_pkg::SelStart: begin out_x = x0_reg; out_y = y0_reg; end
            sgc_pkg::SelEnd: begin out_x = x1_reg; out_y = y1_reg; end
            sgc_pkg::SelCross: begin
                out_x = (cmd.kind == sgc_pkg::KindHorz) ? lres_reg : vx_reg;
                out_y = (cmd.kind == sgc_pkg::KindVert) ? lres_reg : vy_reg;
            end
            default: begin out_x = vx_reg; out_y = vy_reg; end
        endcase
    end
endmodule

/* hdl/sgc_controller.sv */
// Controller of the segment grid crossings unit: sequences divisions,
// interpolation and the output handshake. Uses sgc_pkg.
module sgc_controller (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_tlast,
    output sgc_pkg::cmd_t         cmd,
    input  sgc_pkg::status_t      sts
);
    sgc_pkg::state_t state_reg, state_next;
    logic [2:0] kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sgc_pkg::ST_IDLE;
            kind_reg <= sgc_pkg::KindStart;
        end else begin
            state_reg <= state_next;
            kind_reg <= kind_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next = kind_reg;
        cmd = '0;
        cmd.kind = kind_reg;
        cmd.emit_sel = sgc_pkg::SelCross;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        m_tlast = 1'b0;
        case (state_reg)
            sgc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = sgc_pkg::ST_SETUP;
                end
            end
            sgc_pkg::ST_SETUP: begin
                cmd.setup = 1'b1;
                state_next = sgc_pkg::ST_EMIT_START;
            end
            sgc_pkg::ST_EMIT_START: begin
                cmd.emit_sel = sgc_pkg::SelStart;
                cmd.kind = sgc_pkg::KindStart;
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.start_x_div = 1'b1;
                    state_next = sgc_pkg::ST_XT;
                end
            end
            sgc_pkg::ST_XT: begin
                if (sts.div_done) begin
                    cmd.start_y_div = 1'b1;
                    state_next = sgc_pkg::ST_YT;
                end
            end
            sgc_pkg::ST_YT: begin
                if (sts.div_done) state_next = sgc_pkg::ST_PICK;
            end
            sgc_pkg::ST_PICK: begin
                if (!sts.x_more && !sts.y_more) begin
                    state_next = sgc_pkg::ST_EMIT_END;
                end else if (sts.x_more && sts.y_more && sts.corner) begin
                    kind_next = sgc_pkg::KindCorner;
                    state_next = sgc_pkg::ST_EMIT;
                end else if (sts.x_more && (!sts.y_more || sts.x_first)) begin
                    kind_next = sgc_pkg::KindVert;
                    cmd.start_lerp = 1'b1;
                    cmd.lerp_y = 1'b1;
                    state_next = sgc_pkg::ST_LERP;
                end else begin
                    kind_next = sgc_pkg::KindHorz;
                    cmd.start_lerp = 1'b1;
                    state_next = sgc_pkg::ST_LERP;
                end
            end
            sgc_pkg::ST_LERP: begin
                if (sts.lerp_done) state_next = sgc_pkg::ST_EMIT;
            end
            sgc_pkg::ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.adv_x = kind_reg != sgc_pkg::KindHorz;
                    cmd.adv_y = kind_reg != sgc_pkg::KindVert;
                    cmd.start_x_div = kind_reg != sgc_pkg::KindHorz;
                    cmd.start_y_div = kind_reg == sgc_pkg::KindHorz;
                    state_next = (kind_reg == sgc_pkg::KindCorner) ? sgc_pkg::ST_XT
                                                                  : sgc_pkg::ST_YT;
                end
            end
            sgc_pkg::ST_EMIT_END: begin
                cmd.emit_sel = sgc_pkg::SelEnd;
                cmd.kind = sgc_pkg::KindEnd;
                m_tvalid = 1'b1;
                m_tlast = 1'b1;
                if (m_tready) state_next = sgc_pkg::ST_IDLE;
            end
            default: state_next = sgc_pkg::ST_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("input taken while a result is pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tlast |-> m_tvalid) else $error("last flag without a valid word");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result withdrawn");
endmodule

/* hdl/segment_grid_crossings_unit.sv */
// Segment grid crossings unit: streams the start point, every grid line
// crossing in order of t, and the end point of one segment.
// Input: s_tdata = {end_y, end_x, start_y, start_x}, 17 bits each, lowest first.
// Output: m_tdata = {point_y, point_x}, m_tuser = point_kind, m_tlast = last_point.
// Configuration: cfg_we, cfg_addr (0 grid_points_x, 1 grid_points_y), cfg_wdata.
// One segment is worked on at a time; s_tready is high only when idle.
// After a segment is accepted, the unit passes through a setup state before it offers the start point.
// Each t value comes from the shared bit-serial divider in two 41-step passes,
// line position then t; the shift-add interpolator gives the other coordinate.
// A segment has at most 62 crossings, 31 per axis.
// When the receiver stalls, the current word is held and the unit waits.
// Synchronous reset returns the unit to idle with 5 grid points per axis.
module segment_grid_crossings_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // start_x, start_y, end_x, end_y, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // point_x, point_y, zero pad
    output logic [2:0]  m_tuser,   // point_kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [5:0]  cfg_wdata
);
    logic [5:0] pts_x_reg, pts_y_reg;
    sgc_pkg::cmd_t cmd;
    sgc_pkg::status_t sts;
    logic [16:0] px, py;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pts_x_reg <= 6'd5;
            pts_y_reg <= 6'd5;
        end else if (cfg_we) begin
            if (cfg_addr == sgc_pkg::RegGridY) pts_y_reg <= cfg_wdata;
            else pts_x_reg <= cfg_wdata;
        end
    end

    sgc_controller u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tlast,
        .cmd, .sts
    );

    sgc_datapath u_dp (
        .aclk, .aresetn, .cmd, .sts, .pts_x(pts_x_reg), .pts_y(pts_y_reg),
        .in_data(s_tdata[67:0]), .out_x(px), .out_y(py)
    );

    assign m_tdata = {6'd0, py, px};
    assign m_tuser = cmd.kind;
endmodule

/* dv/segment_grid_crossings_unit_tb.sv */
// Testbench for segment_grid_crossings_unit: drives segments under several grid settings
// and checks every emitted point against a built-in predictor (typed rows: listed points).
// Depends on hdl/sgc_pkg.sv and hdl/segment_grid_crossings_unit.sv.
module segment_grid_crossings_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned CoordOneL = 64'd65536;
    localparam longint unsigned TOneL = 64'd1 << sgc_pkg::TFrac;

    typedef struct {
        logic [16:0] x;
        logic [16:0] y;
        logic [2:0]  kind;
        logic        last;
    } point_t;

    typedef struct {
        logic [16:0] sx, sy, ex, ey;
        bit          typed;
        logic [16:0] ax, ay, bx, by;
    } row_t;

    typedef struct {
        logic [5:0] gx, gy;
        int         count;
    } phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [5:0]  cfg_wdata = '0;

    point_t pending_points[$];
    logic [5:0] grid_x_reg = 6'd5;
    logic [5:0] grid_y_reg = 6'd5;
    int errors = 0;
    int points_seen = 0;
    int segments_sent = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    row_t directed[16] = '{
        '{0, 0, 0, 0, 1, 0, 0, 0, 0},
        '{131071, 131071, 131071, 131071, 1, 65536, 65536, 65536, 65536},
        '{100, 200, 300, 400, 1, 100, 200, 300, 400},
        '{65536, 0, 65536, 0, 1, 65536, 0, 65536, 0},
        '{0, 0, 65536, 65536, 0, 0, 0, 0, 0},
        '{65536, 65536, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1000, 65536, 1000, 0, 0, 0, 0, 0},
        '{30000, 0, 30000, 65536, 0, 0, 0, 0, 0},
        '{131071, 0, 0, 131071, 0, 0, 0, 0, 0},
        '{16384, 16384, 49152, 49152, 0, 0, 0, 0, 0},
        '{16384, 0, 16383, 65536, 0, 0, 0, 0, 0},
        '{1, 65535, 65535, 1, 0, 0, 0, 0, 0},
        '{17'h15555, 17'h0AAAA, 17'h0AAAA, 17'h15555, 0, 0, 0, 0, 0},
        '{0, 0, 65536, 1, 0, 0, 0, 0, 0},
        '{12345, 60000, 54321, 7, 0, 0, 0, 0, 0},
        '{32768, 32768, 32768, 32769, 0, 0, 0, 0, 0}
    };

    phase_t phases[12] = '{
        '{6'd2, 6'd2, 30}, '{6'd32, 6'd32, 8}, '{6'd0, 6'd63, 8}, '{6'd1, 6'd33, 10},
        '{6'd63, 6'd0, 8}, '{6'd3, 6'd7, 25}, '{6'd9, 6'd4, 25}, '{6'd0, 6'd0, 30},
        '{6'd0, 6'd0, 30}, '{6'd0, 6'd0, 30}, '{6'd0, 6'd0, 30}, '{6'd6, 6'd6, 30}
    };

    segment_grid_crossings_unit uut (.*);

    always #2 aclk = ~aclk;

    function automatic void queue_point(point_t p);
        pending_points.insert(pending_points.size(), p);
    endfunction

    function automatic longint unsigned clamp_points(logic [5:0] n);
        if (n < 2) return 2;
        if (n > 32) return 32;
        return n;
    endfunction

    function automatic longint unsigned sat(logic [16:0] c);
        return (c > sgc_pkg::CoordOne) ? CoordOneL : longint'(c);
    endfunction

    function automatic int axis_hits(longint unsigned c0, longint unsigned c1,
                                     longint unsigned n, output longint unsigned val[32],
                                     output longint unsigned tt[32]);
        longint unsigned seg, i0, i1, len, lo, hi, ind, v, d, t;
        int cnt;
        seg = n - 1;
        i0 = (c0 * seg) >> 16;
        i1 = (c1 * seg) >> 16;
        len = (c0 > c1) ? c0 - c1 : c1 - c0;
        cnt = 0;
        if (i0 == i1 || len == 0) return 0;
        lo = (i0 < i1) ? i0 + 1 : i1 + 1;
        hi = (i0 < i1) ? i1 : i0;
        for (int k = 0; k < 32; k++) begin
            ind = (i0 < i1) ? lo + k : hi - k;
            if (ind < lo || ind > hi) break;
            v = (ind * CoordOneL) / seg;
            d = (v > c0) ? v - c0 : c0 - v;
            t = (d << sgc_pkg::TFrac) / len;
            if (t > TOneL) t = TOneL;
            val[cnt] = v;
            tt[cnt] = t;
            cnt++;
        end
        return cnt;
    endfunction

    function automatic logic [16:0] blend(longint unsigned a, longint unsigned b,
                                          longint unsigned t);
        return 17'(((TOneL - t) * a + t * b) >> sgc_pkg::TFrac);
    endfunction

    function automatic void predict_points(logic [16:0] sx, logic [16:0] sy,
                                           logic [16:0] ex, logic [16:0] ey);
        longint unsigned x0, y0, x1, y1;
        longint unsigned xv[32], xt[32], yv[32], yt[32];
        int nx, ny, ix, iy;
        x0 = sat(sx);
        y0 = sat(sy);
        x1 = sat(ex);
        y1 = sat(ey);
        nx = axis_hits(x0, x1, clamp_points(grid_x_reg), xv, xt);
        ny = axis_hits(y0, y1, clamp_points(grid_y_reg), yv, yt);
        ix = 0;
        iy = 0;
        queue_point('{17'(x0), 17'(y0), sgc_pkg::KindStart, 1'b0});
        while (ix < nx || iy < ny) begin
            if (ix < nx && iy < ny && xt[ix] == yt[iy]) begin
                queue_point('{17'(xv[ix]), 17'(yv[iy]), sgc_pkg::KindCorner, 1'b0});
                ix++;
                iy++;
            end else if (ix < nx && (iy >= ny || xt[ix] < yt[iy])) begin
                queue_point('{17'(xv[ix]), blend(y0, y1, xt[ix]), sgc_pkg::KindVert,
                              1'b0});
                ix++;
            end else begin
                queue_point('{blend(x0, x1, yt[iy]), 17'(yv[iy]), sgc_pkg::KindHorz,
                              1'b0});
                iy++;
            end
        end
        queue_point('{17'(x1), 17'(y1), sgc_pkg::KindEnd, 1'b1});
    endfunction

    function automatic logic [16:0] pick_coord(logic [5:0] n);
        longint unsigned seg;
        seg = clamp_points(n) - 1;
        case ($urandom_range(0, 9))
            0: return 17'($urandom_range(65537, 131071));
            1: return 17'((longint'($urandom_range(0, seg)) * CoordOneL) / seg);
            2: return $urandom_range(0, 1) ? sgc_pkg::CoordOne : 17'd0;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Sends one segment; valid stays high on return unless the task drops it at random.
    task automatic send_segment(row_t r);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, r.ey, r.ex, r.sy, r.sx};
        do @(posedge aclk); while (!s_tready);
        if (r.typed) begin
            queue_point('{r.ax, r.ay, sgc_pkg::KindStart, 1'b0});
            queue_point('{r.bx, r.by, sgc_pkg::KindEnd, 1'b1});
        end else begin
            predict_points(r.sx, r.sy, r.ex, r.ey);
        end
        segments_sent++;
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge aclk);
        end
    endtask

    task automatic write_grid(logic [5:0] gx, logic [5:0] gy);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (200) @(posedge aclk);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= sgc_pkg::RegGridX;
        cfg_wdata <= gx;
        @(negedge aclk);
        cfg_addr <= sgc_pkg::RegGridY;
        cfg_wdata <= gy;
        @(negedge aclk);
        cfg_we <= 1'b0;
        grid_x_reg = gx;
        grid_y_reg = gy;
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        point_t want;
        if (aresetn && m_tvalid && m_tready) begin
            points_seen++;
            if (pending_points.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected word: x=%0d y=%0d kind=%0d last=%0d",
                             m_tdata[16:0], m_tdata[33:17], m_tuser, m_tlast);
            end else begin
                want = pending_points[0];
                pending_points.delete(0);
                if (m_tdata[16:0] !== want.x || m_tdata[33:17] !== want.y ||
                    m_tuser !== want.kind || m_tlast !== want.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Mismatch: expected x=%0d y=%0d kind=%0d last=%0d",
                                 want.x, want.y, want.kind, want.last);
                        $display("          got      x=%0d y=%0d kind=%0d last=%0d",
                                 m_tdata[16:0], m_tdata[33:17], m_tuser, m_tlast);
                    end
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("Run timed out.");
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        row_t r;
        logic [5:0] gx, gy;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (directed[i]) send_segment(directed[i]);
        foreach (phases[p]) begin
            gx = phases[p].gx;
            gy = phases[p].gy;
            if (gx == 0 && gy == 0) begin
                gx = 6'($urandom_range(2, 12));
                gy = 6'($urandom_range(2, 12));
            end
            write_grid(gx, gy);
            if (p == $size(phases) - 1) calm = 1'b1;
            if (p == 5) hold_req = 1'b1;
            for (int i = 0; i < phases[p].count; i++) begin
                r.typed = 1'b0;
                r.sx = pick_coord(gx);
                r.sy = pick_coord(gy);
                r.ex = ($urandom_range(0, 9) == 0) ? r.sx : pick_coord(gx);
                r.ey = ($urandom_range(0, 9) == 0) ? r.sy : pick_coord(gy);
                if (!calm && $urandom_range(0, 19) == 0) begin
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    wait (pending_points.size() == 0);
                end
                send_segment(r);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (300) @(posedge aclk);
        $display("Sent %0d segments over %0d grid settings and checked %0d points.",
                 segments_sent, $size(phases) + 1, points_seen);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches in total.", errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* segment_grid_crossings_unit.f */
hdl/sgc_pkg.sv
hdl/sgc_datapath.sv
hdl/sgc_controller.sv
hdl/segment_grid_crossings_unit.sv
dv/segment_grid_crossings_unit_tb.sv
